@@ design/mntg_pkg.sv @@
// Package for the melody note tone generator: payload types, register map and tables.
package mntg_pkg;

  // 10us ticks in one 10ms length unit
  localparam int unsigned TICKS_PER_UNIT = 1000;
  localparam int unsigned PRE_W = $clog2(TICKS_PER_UNIT + 1);

  localparam logic [15:0] DIVIDEND = 16'd50000;
  localparam logic [7:0]  BEAT_DEFAULT = 8'd128;
  localparam logic [7:0]  BEAT_MIN = 8'd10;
  localparam logic [7:0]  BEAT_MAX = 8'd250;

  // input function codes
  localparam logic [1:0] FN_NOTE = 2'd0;
  localparam logic [1:0] FN_TICK = 2'd1;
  localparam logic [1:0] FN_STOP = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_KEY    = 2'd0;
  localparam logic [1:0] REG_OCTAVE = 2'd1;
  localparam logic [1:0] REG_BEAT   = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] pitch_code;
    logic [7:0] length_code;
  } in_item_t;

  typedef struct packed {
    logic        wave_level;
    logic        busy_res;
    logic        note_taken;
    logic [11:0] half_period;
    logic [9:0]  sound_len;
    logic [8:0]  rest_len;
  } out_item_t;

  typedef struct packed {
    logic [1:0] hun;
    logic [3:0] ten;
    logic [3:0] one;
  } digits_t;

  // split an 8-bit value into decimal digits
  function automatic digits_t dec_digits(logic [7:0] x);
    digits_t     d;
    logic [7:0]  r8;
    logic [6:0]  r;
    logic [14:0] prod;
    logic [6:0]  ten10;
    if (x >= 8'd200) begin
      d.hun = 2'd2;
      r8 = x - 8'd200;
    end else if (x >= 8'd100) begin
      d.hun = 2'd1;
      r8 = x - 8'd100;
    end else begin
      d.hun = 2'd0;
      r8 = x;
    end
    r = r8[6:0];
    // r / 10 as r * 205 >> 11, exact below 1029
    prod = 15'(r) * 15'd205;
    d.ten = prod[14:11];
    ten10 = (7'(d.ten) << 3) + (7'(d.ten) << 1);
    d.one = 4'(r - ten10);
    return d;
  endfunction

  // semitone frequencies in Hz
  function automatic logic [9:0] tone_hz(logic [3:0] idx);
    logic [9:0] f;
    case (idx)
      4'd0:    f = 10'd262;
      4'd1:    f = 10'd277;
      4'd2:    f = 10'd294;
      4'd3:    f = 10'd311;
      4'd4:    f = 10'd330;
      4'd5:    f = 10'd349;
      4'd6:    f = 10'd370;
      4'd7:    f = 10'd392;
      4'd8:    f = 10'd415;
      4'd9:    f = 10'd440;
      4'd10:   f = 10'd466;
      4'd11:   f = 10'd494;
      default: f = 10'd262;
    endcase
    return f;
  endfunction

  // scale degree (0 based) to semitone
  function automatic logic [3:0] degree_semi(logic [2:0] deg);
    logic [3:0] s;
    case (deg)
      3'd0:    s = 4'd0;
      3'd1:    s = 4'd2;
      3'd2:    s = 4'd4;
      3'd3:    s = 4'd5;
      3'd4:    s = 4'd7;
      3'd5:    s = 4'd9;
      3'd6:    s = 4'd11;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  // subdivision digit to log2 of the beat divisor
  function automatic logic [2:0] subdiv_shift(logic [3:0] code);
    logic [2:0] sh;
    case (code)
      4'd0:    sh = 3'd0;
      4'd1:    sh = 3'd1;
      4'd2:    sh = 3'd2;
      4'd3:    sh = 3'd3;
      4'd4:    sh = 3'd4;
      4'd5:    sh = 3'd5;
      4'd6:    sh = 3'd6;
      default: sh = 3'd2;
    endcase
    return sh;
  endfunction

endpackage

@@ design/melody_note_tone_generator.sv @@
// Melody note tone generator top level: note decode, shared divider, tone and note timers.

// One result beat per input beat, one input beat in work at a time. Tick, stop, no-op,
// end-of-song and ignored notes are worked out in the cycle they are accepted and their
// result is registered at that edge. A note taken while idle goes through a decode step,
// a prepare step, the shared restoring divider (50000 / frequency) and a finish step, in
// which its result is registered; an invalid note skips the divider. A new input beat is
// taken only while the sequencer is idle and the output register is empty or being emptied
// in the same cycle, so a stalled result beat stalls the input. Config writes take effect
// when a note reaches the prepare step; prdata returns the raw register values.
module melody_note_tone_generator (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mntg_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mntg_pkg::out_item_t   out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import mntg_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DEC  = 5'b00010,
    S_PREP = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } ctl_state_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_SOUND = 3'b010,
    PH_REST  = 3'b100
  } phase_t;

  // configuration
  logic [3:0] key_r, oct_r;
  logic [7:0] beat_r;

  // control
  ctl_state_t st_r, st_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  // player state
  phase_t     phase_r, phase_nxt;
  logic [11:0] period_r, period_nxt;
  logic [11:0] wave_r, wave_nxt;
  logic [PRE_W-1:0] pre_r, pre_nxt;
  logic [9:0] unit_r, unit_nxt;
  logic [9:0] sound_r, sound_nxt;
  logic [8:0] rest_r, rest_nxt;
  logic       level_r, level_nxt;

  // note work registers
  in_item_t   item_r;
  digits_t    pd_r, ld_r;
  logic       note_ok_r;
  logic [9:0] snd_pend_r;
  logic [8:0] rst_pend_r;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [15:0] dvs_r;
  out_item_t  out_r, out_nxt;

  logic acc, slot_free, direct, taken_c, out_load, cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_KEY:    prdata = {28'd0, key_r};
      REG_OCTAVE: prdata = {28'd0, oct_r};
      REG_BEAT:   prdata = {24'd0, beat_r};
      default:    prdata = 32'd0;
    endcase
  end

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (st_r == S_IDLE) && slot_free;
  assign acc       = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------- note preparation (used in S_PREP) ----------------
  logic [3:0]  key_eff, semi, s_idx;
  logic        wrapped;
  logic [4:0]  j_idx;
  logic [15:0] freq;
  logic        units_ok;
  logic [7:0]  beat_eff, beat_q;
  logic [2:0]  sh;
  logic [9:0]  snd0, snd, rst_len, snd_len;
  logic [17:0] third;

  always_comb begin
    key_eff  = (key_r > 4'd11) ? 4'd0 : key_r;
    units_ok = pd_r.one inside {[4'd1:4'd7]};
    semi     = degree_semi(3'(pd_r.one - 4'd1)) + 4'(pd_r.hun);
    wrapped  = semi > 4'd11;
    s_idx    = wrapped ? semi - 4'd12 : semi;
    j_idx    = 5'(s_idx) + 5'(key_eff);
    if (j_idx > 5'd11) begin
      freq = {5'd0, tone_hz(4'(j_idx - 5'd12)), 1'b0};
    end else begin
      freq = {6'd0, tone_hz(j_idx[3:0])};
    end
    case (oct_r)
      4'd1:    freq = freq >> 3;
      4'd2:    freq = freq >> 2;
      4'd3:    freq = freq >> 1;
      4'd5:    freq = freq << 1;
      4'd6:    freq = freq << 2;
      4'd7:    freq = freq << 3;
      default: freq = freq;
    endcase
    if (wrapped) begin
      freq = freq << 1;
    end
    if (pd_r.ten == 4'd1) begin
      freq = freq >> 1;
    end else if (pd_r.ten == 4'd3) begin
      freq = freq << 1;
    end

    beat_eff = (beat_r < BEAT_MIN || beat_r > BEAT_MAX) ? BEAT_DEFAULT : beat_r;
    sh       = subdiv_shift(ld_r.one);
    beat_q   = beat_eff >> sh;
    snd0     = {1'b0, beat_q, 1'b0};
    snd      = (ld_r.hun == 2'd1) ? snd0 + (snd0 >> 1) : snd0;
    // snd / 3 as snd * 171 >> 9; only used for short notes (snd below 512)
    third    = 18'(snd) * 18'd171;
    if (sh < 3'd2) begin
      rst_len = {4'd0, beat_eff[7:2]};
    end else begin
      rst_len = {1'b0, third[17:9]};
    end
    if (ld_r.ten == 4'd1) begin
      rst_len = 10'd0;
    end else if (ld_r.ten == 4'd2) begin
      rst_len = snd >> 1;
    end
    snd_len = snd - rst_len;
  end

  // ---------------- shared divider step ----------------
  logic [16:0] trial;
  logic        ge;
  always_comb begin
    trial   = {rem_r, quo_r[15]};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? 16'(trial - {1'b0, dvs_r}) : trial[15:0];
    quo_nxt = {quo_r[14:0], ge};
  end

  // ---------------- sequencer and player ----------------
  logic [11:0] wave_inc;
  logic [PRE_W:0] pre_inc;
  logic [9:0] unit_inc;

  always_comb begin
    st_nxt     = st_r;
    cnt_nxt    = cnt_r;
    phase_nxt  = phase_r;
    period_nxt = period_r;
    wave_nxt   = wave_r;
    pre_nxt    = pre_r;
    unit_nxt   = unit_r;
    sound_nxt  = sound_r;
    rest_nxt   = rest_r;
    level_nxt  = level_r;
    direct     = 1'b0;
    taken_c    = 1'b0;
    out_load   = 1'b0;
    wave_inc   = wave_r + 12'd1;
    pre_inc    = {1'b0, pre_r} + (PRE_W+1)'(1);
    unit_inc   = unit_r + 10'd1;

    case (st_r)
      S_IDLE: begin
        if (acc) begin
          direct = 1'b1;
          case (in_data.func)
            FN_NOTE: begin
              if (phase_r == PH_IDLE) begin
                taken_c = 1'b1;
                if (in_data.pitch_code == 8'd0) begin
                  // end of song
                  period_nxt = 12'd0;
                  level_nxt  = 1'b0;
                  wave_nxt   = 12'd0;
                  pre_nxt    = '0;
                  unit_nxt   = 10'd0;
                  sound_nxt  = 10'd0;
                  rest_nxt   = 9'd0;
                end else begin
                  direct = 1'b0;
                  st_nxt = S_DEC;
                end
              end
            end
            FN_TICK: begin
              if (phase_r == PH_IDLE) begin
                wave_nxt = 12'd0;
              end else begin
                if (period_r != 12'd0) begin
                  if (wave_inc >= period_r) begin
                    level_nxt = ~level_r;
                    wave_nxt  = 12'd0;
                  end else begin
                    wave_nxt = wave_inc;
                  end
                end else begin
                  wave_nxt = 12'd0;
                end
                if (pre_inc >= (PRE_W+1)'(TICKS_PER_UNIT)) begin
                  pre_nxt  = '0;
                  unit_nxt = unit_inc;
                  if ((phase_r == PH_SOUND && unit_inc >= sound_r) ||
                      (phase_r == PH_REST && unit_inc >= {1'b0, rest_r})) begin
                    // sound over: go to rest, or idle after the rest
                    period_nxt = 12'd0;
                    level_nxt  = 1'b0;
                    wave_nxt   = 12'd0;
                    unit_nxt   = 10'd0;
                    if (phase_r == PH_SOUND && rest_r != 9'd0) begin
                      phase_nxt = PH_REST;
                    end else begin
                      phase_nxt = PH_IDLE;
                    end
                  end
                end else begin
                  pre_nxt = pre_inc[PRE_W-1:0];
                end
              end
            end
            FN_STOP: begin
              phase_nxt  = PH_IDLE;
              period_nxt = 12'd0;
              level_nxt  = 1'b0;
              wave_nxt   = 12'd0;
              pre_nxt    = '0;
              unit_nxt   = 10'd0;
              sound_nxt  = 10'd0;
              rest_nxt   = 9'd0;
            end
            default: ;
          endcase
        end
      end
      S_DEC: begin
        st_nxt = S_PREP;
      end
      S_PREP: begin
        cnt_nxt = 4'd0;
        st_nxt  = units_ok ? S_DIV : S_FIN;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          st_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          taken_c   = 1'b1;
          level_nxt = 1'b0;
          wave_nxt  = 12'd0;
          pre_nxt   = '0;
          unit_nxt  = 10'd0;
          sound_nxt = snd_pend_r;
          rest_nxt  = rst_pend_r;
          if (snd_pend_r == 10'd0) begin
            period_nxt = 12'd0;
            phase_nxt  = (rst_pend_r == 9'd0) ? PH_IDLE : PH_REST;
          end else begin
            period_nxt = note_ok_r ? quo_r[11:0] : 12'd0;
            phase_nxt  = PH_SOUND;
          end
          out_load = 1'b1;
          st_nxt   = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    if (acc && direct) begin
      out_load = 1'b1;
    end

    out_nxt.wave_level  = level_nxt;
    out_nxt.busy_res    = phase_nxt != PH_IDLE;
    out_nxt.note_taken  = taken_c;
    out_nxt.half_period = period_nxt;
    out_nxt.sound_len   = sound_nxt;
    out_nxt.rest_len    = rest_nxt;

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control and player state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= 4'd0;
      phase_r     <= PH_IDLE;
      period_r    <= 12'd0;
      wave_r      <= 12'd0;
      pre_r       <= '0;
      unit_r      <= 10'd0;
      sound_r     <= 10'd0;
      rest_r      <= 9'd0;
      level_r     <= 1'b0;
      key_r       <= 4'd0;
      oct_r       <= 4'd5;
      beat_r      <= BEAT_DEFAULT;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      phase_r     <= phase_nxt;
      period_r    <= period_nxt;
      wave_r      <= wave_nxt;
      pre_r       <= pre_nxt;
      unit_r      <= unit_nxt;
      sound_r     <= sound_nxt;
      rest_r      <= rest_nxt;
      level_r     <= level_nxt;
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_KEY:    key_r  <= pwdata[3:0];
          REG_OCTAVE: oct_r  <= pwdata[3:0];
          REG_BEAT:   beat_r <= pwdata[7:0];
          default: ;
        endcase
      end
    end
  end

  // payload and work registers
  always_ff @(posedge clk) begin
    if (acc) begin
      item_r <= in_data;
    end
    if (st_r == S_DEC) begin
      pd_r <= dec_digits(item_r.pitch_code);
      ld_r <= dec_digits(item_r.length_code);
    end
    if (st_r == S_PREP) begin
      note_ok_r  <= units_ok;
      snd_pend_r <= snd_len;
      rst_pend_r <= rst_len[8:0];
      rem_r      <= 16'd0;
      quo_r      <= DIVIDEND;
      dvs_r      <= freq;
    end else if (st_r == S_DIV) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

`ifndef ASSERT_OFF
  // a tone only plays while a note is sounding
  a_tone_needs_sound: assert property (@(posedge clk) disable iff (!rst_n)
    (period_r != 12'd0) |-> (phase_r == PH_SOUND))
    else $error("half period set outside the sounding phase");

  // a sounding note always has a nonzero sound length
  a_sound_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SOUND) |-> (sound_r != 10'd0))
    else $error("sounding with zero sound length");

  // the finish step is reached only from the divider or the prepare step
  a_fin_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_FIN && $past(st_r) != S_FIN) |->
      ($past(st_r) == S_DIV && $past(cnt_r) == 4'd15) || $past(st_r) == S_PREP)
    else $error("finish step entered out of sequence");

  // results are not loaded over an undelivered beat
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(out_r))
    else $error("pending result overwritten");
`endif

endmodule

@@ tb/sv/melody_note_tone_generator_tb.sv @@
// Self-checking testbench for the melody note tone generator: note, tick, stop and no-op beats, and register writes.
`timescale 1ns / 100ps

module melody_note_tone_generator_tb;
  import mntg_pkg::*;

  localparam logic [1:0] FN_NOP = 2'd3;
  localparam int LIMIT = 400_000;
  localparam int SETTLE = 40;
  localparam int HOLD_CYCLES = 300;

  localparam int unsigned SEMI_HZ [12] = '{262, 277, 294, 311, 330, 349,
                                           370, 392, 415, 440, 466, 494};
  localparam int unsigned DEGREE_STEP [7] = '{0, 2, 4, 5, 7, 9, 11};
  localparam int unsigned SUBDIV [10] = '{1, 2, 4, 8, 16, 32, 64, 4, 4, 4};

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SOUND = 2'd1,
    PH_REST  = 2'd2
  } tone_phase_e;

  typedef struct packed {
    in_item_t  beat;
    logic      typed;
    out_item_t want;
  } vec_row_t;

  localparam out_item_t OUT_QUIET = '0;
  localparam out_item_t OUT_SONG_END = '{1'b0, 1'b0, 1'b1, 12'd0, 10'd0, 9'd0};

  // directed beats under the reset settings; typed rows carry their own expectation
  localparam int DIR_N = 25;
  localparam vec_row_t DIR_TAB [DIR_N] = '{
    '{'{FN_TICK, 8'd0,   8'd0},   1'b1, OUT_QUIET},     // tick while idle
    '{'{FN_NOP,  8'd255, 8'd255}, 1'b1, OUT_QUIET},
    '{'{FN_STOP, 8'd0,   8'd0},   1'b1, OUT_QUIET},
    '{'{FN_NOTE, 8'd0,   8'd255}, 1'b1, OUT_SONG_END},  // end of song
    '{'{FN_NOTE, 8'd255, 8'd255}, 1'b0, OUT_QUIET},
    '{'{FN_NOTE, 8'd1,   8'd0},   1'b0, OUT_QUIET},     // busy, ignored
    '{'{FN_TICK, 8'd0,   8'd0},   1'b0, OUT_QUIET},
    '{'{FN_TICK, 8'd255, 8'd255}, 1'b0, OUT_QUIET},
    '{'{FN_NOP,  8'd0,   8'd0},   1'b0, OUT_QUIET},
    '{'{FN_STOP, 8'd255, 8'd255}, 1'b1, OUT_QUIET},
    '{'{FN_NOTE, 8'd10,  8'd0},   1'b0, OUT_QUIET},     // invalid note, silent
    '{'{FN_TICK, 8'd0,   8'd0},   1'b0, OUT_QUIET},
    '{'{FN_STOP, 8'd0,   8'd0},   1'b1, OUT_QUIET},
    '{'{FN_NOTE, 8'd8,   8'd9},   1'b0, OUT_QUIET},
    '{'{FN_STOP, 8'd0,   8'd0},   1'b1, OUT_QUIET},
    '{'{FN_NOTE, 8'd237, 8'd120}, 1'b0, OUT_QUIET},     // semitone past 11, dotted staccato
    '{'{FN_TICK, 8'd0,   8'd0},   1'b0, OUT_QUIET},
    '{'{FN_STOP, 8'd0,   8'd0},   1'b1, OUT_QUIET},
    '{'{FN_NOTE, 8'd211, 8'd16},  1'b0, OUT_QUIET},     // octave down, legato
    '{'{FN_STOP, 8'd0,   8'd0},   1'b1, OUT_QUIET},
    '{'{FN_NOTE, 8'd129, 8'd7},   1'b0, OUT_QUIET},
    '{'{FN_STOP, 8'd0,   8'd0},   1'b1, OUT_QUIET},
    '{'{FN_NOTE, 8'd31,  8'd200}, 1'b0, OUT_QUIET},     // octave up
    '{'{FN_NOTE, 8'd0,   8'd0},   1'b0, OUT_QUIET},     // song end while busy, ignored
    '{'{FN_STOP, 8'd0,   8'd0},   1'b1, OUT_QUIET}
  };

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  melody_note_tone_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // tone model state and settings
  tone_phase_e tone_phase;
  logic [15:0] half_per_q, wave_cnt, pre_cnt, unit_cnt, sound_q, rest_q;
  logic        level_q;
  logic [3:0]  cfg_key, cfg_oct;
  logic [7:0]  cfg_beat;
  bit          note_hit;

  out_item_t tone_due [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;
  int fail_cnt = 0;
  int checked = 0;
  int beats_sent = 0;
  int beats_counted = 0;
  int notes_taken = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("melody_note_tone_generator verification failed");
      $finish;
    end
  end

  // ---------------- tone model ----------------

  function automatic int unsigned semi_to_hz(int unsigned semi);
    int unsigned key, s, j, f;
    bit          wrap;
    key = (cfg_key > 4'd11) ? 0 : cfg_key;
    wrap = semi > 11;
    s = wrap ? semi - 12 : semi;
    j = s + key;
    f = (j > 11) ? (SEMI_HZ[(j - 12) % 12] << 1) : SEMI_HZ[j % 12];
    case (cfg_oct)
      4'd1: f = f >> 3;
      4'd2: f = f >> 2;
      4'd3: f = f >> 1;
      4'd5: f = f << 1;
      4'd6: f = f << 2;
      4'd7: f = f << 3;
      default: ;
    endcase
    if (wrap) f = f << 1;
    return f;
  endfunction

  function automatic void go_quiet();
    tone_phase = PH_IDLE;
    half_per_q = '0;
    level_q = 1'b0;
    wave_cnt = '0;
    pre_cnt = '0;
    unit_cnt = '0;
  endfunction

  function automatic void enter_rest();
    go_quiet();
    tone_phase = (rest_q == 0) ? PH_IDLE : PH_REST;
  endfunction

  function automatic void start_note(int unsigned pc, int unsigned lc);
    int unsigned units, oct, hund, beat, dv, kind, dotted, f, snd, rst;
    units = pc % 10;
    oct = (pc / 10) % 10;
    hund = pc / 100;
    beat = (cfg_beat < 8'd10 || cfg_beat > 8'd250) ? 128 : cfg_beat;
    dv = SUBDIV[lc % 10];
    kind = (lc / 10) % 10;
    dotted = lc / 100;
    if (units >= 1 && units <= 7) begin
      f = semi_to_hz(DEGREE_STEP[units - 1] + hund);
      if (oct == 1) f = f >> 1;
      else if (oct == 3) f = f << 1;
      half_per_q = (f != 0) ? 16'(50000 / f) : 16'd0;
    end else begin
      half_per_q = '0;
    end
    snd = (beat / dv) << 1;
    if (dotted == 1) snd = snd + (snd >> 1);
    rst = (dv < 4) ? (beat >> 2) : (snd / 3);
    if (kind == 1) rst = 0;
    else if (kind == 2) rst = snd >> 1;
    sound_q = 16'(snd - rst);
    rest_q = 16'(rst);
    level_q = 1'b0;
    wave_cnt = '0;
    pre_cnt = '0;
    unit_cnt = '0;
    tone_phase = PH_SOUND;
    if (sound_q == 0) enter_rest();
  endfunction

  function automatic void tone_tick();
    if (tone_phase != PH_SOUND && tone_phase != PH_REST) begin
      wave_cnt = '0;
      return;
    end
    if (half_per_q != 0) begin
      wave_cnt = (wave_cnt + 16'd1) & 16'hFFF;
      if (wave_cnt >= half_per_q) begin
        level_q = ~level_q;
        wave_cnt = '0;
      end
    end else begin
      wave_cnt = '0;
    end
    pre_cnt = pre_cnt + 16'd1;
    if (pre_cnt >= TICKS_PER_UNIT) begin
      pre_cnt = '0;
      unit_cnt = (unit_cnt + 16'd1) & 16'h3FF;
      if (tone_phase == PH_SOUND) begin
        if (unit_cnt >= sound_q) enter_rest();
      end else if (unit_cnt >= rest_q) begin
        go_quiet();
      end
    end
  endfunction

  function automatic out_item_t predict_tone(in_item_t b);
    out_item_t r;
    note_hit = 1'b0;
    case (b.func)
      FN_NOTE: begin
        if (tone_phase == PH_IDLE) begin
          note_hit = 1'b1;
          if (b.pitch_code == 0) begin
            go_quiet();
            sound_q = '0;
            rest_q = '0;
          end else begin
            start_note(b.pitch_code, b.length_code);
          end
        end
      end
      FN_TICK: tone_tick();
      FN_STOP: begin
        go_quiet();
        sound_q = '0;
        rest_q = '0;
      end
      default: ;
    endcase
    r.wave_level = level_q;
    r.busy_res = (tone_phase == PH_SOUND || tone_phase == PH_REST);
    r.note_taken = note_hit;
    r.half_period = half_per_q[11:0];
    r.sound_len = sound_q[9:0];
    r.rest_len = rest_q[8:0];
    return r;
  endfunction

  // ---------------- checking ----------------

  task automatic field_chk(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", fname, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin : result_mon
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (tone_due.size() == 0) begin
        $error("result beat with nothing expected: %h", out_data);
        fail_cnt++;
      end else begin
        want = tone_due.pop_front();
        field_chk("wave_level", want.wave_level, out_data.wave_level);
        field_chk("busy_res", want.busy_res, out_data.busy_res);
        field_chk("note_taken", want.note_taken, out_data.note_taken);
        field_chk("half_period", want.half_period, out_data.half_period);
        field_chk("sound_len", want.sound_len, out_data.sound_len);
        field_chk("rest_len", want.rest_len, out_data.rest_len);
        checked++;
      end
    end
  end

  // result side: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------- stimulus ----------------

  task automatic send_beat(input in_item_t b, input logic typed, input out_item_t want);
    out_item_t pred;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    pred = predict_tone(b);
    tone_due.push_back(typed ? want : pred);
    beats_sent++;
    if (note_hit) notes_taken++;
    if (!(b.func == FN_NOTE && !note_hit)) beats_counted++;
  endtask

  task automatic send_plain(input logic [1:0] fn, input logic [7:0] pc, input logic [7:0] lc);
    in_item_t b;
    b.func = fn;
    b.pitch_code = pc;
    b.length_code = lc;
    send_beat(b, 1'b0, OUT_QUIET);
  endtask

  // let everything in flight drain before touching the registers
  task automatic quiesce();
    in_valid <= 1'b0;
    while (tone_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    logic [31:0] mask;
    mask = (idx == REG_BEAT) ? 32'hFF : 32'hF;
    case (idx)
      REG_KEY:    cfg_key = value[3:0];
      REG_OCTAVE: cfg_oct = value[3:0];
      default:    cfg_beat = value;
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= ($urandom & ~mask) | (32'(value) & mask);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // straight into a read of the same register
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    field_chk("prdata", 32'(value) & mask, prdata & mask);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [7:0] key, input logic [7:0] oct, input logic [7:0] beat);
    write_reg(REG_KEY, key);
    write_reg(REG_OCTAVE, oct);
    write_reg(REG_BEAT, beat);
  endtask

  task automatic random_step();
    int r, n;
    r = $urandom_range(99);
    if (tone_phase == PH_IDLE) begin
      if (r < 65) begin
        if ($urandom_range(19) == 0) send_plain(FN_NOTE, 8'd0, 8'($urandom));
        else send_plain(FN_NOTE, 8'($urandom), 8'($urandom));
      end else if (r < 80) begin
        send_plain(FN_TICK, 8'($urandom), 8'($urandom));
      end else if (r < 90) begin
        send_plain(FN_STOP, 8'($urandom), 8'($urandom));
      end else begin
        send_plain(FN_NOP, 8'($urandom), 8'($urandom));
      end
    end else if (r < 70) begin
      n = $urandom_range(8, 1);
      repeat (n) send_plain(FN_TICK, 8'($urandom), 8'($urandom));
    end else if (r < 84) begin
      send_plain(FN_STOP, 8'($urandom), 8'($urandom));
    end else if (r < 92) begin
      send_plain(FN_NOTE, 8'($urandom), 8'($urandom));
    end else begin
      send_plain(FN_NOP, 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic random_run(input int count);
    int start;
    start = beats_counted;
    while (beats_counted - start < count) random_step();
  endtask

  initial begin
    cfg_key = 4'd0;
    cfg_oct = 4'd5;
    cfg_beat = 8'd128;
    go_quiet();
    sound_q = '0;
    rest_q = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) send_beat(DIR_TAB[i].beat, DIR_TAB[i].typed, DIR_TAB[i].want);

    // no idling; shortest beat
    quiesce();
    set_regs(8'd11, 8'd7, 8'd10);
    send_plain(FN_NOTE, 8'd1, 8'd6);   // zero sound and rest: stays idle
    send_plain(FN_NOTE, 8'd2, 8'd4);
    random_run(125);

    quiesce();
    idle_pct = 73;
    set_regs(8'd15, 8'd1, 8'd255);
    random_run(125);

    // receiver stalls, with one long hold-off right at the start
    quiesce();
    idle_pct = 0;
    stall_pct = 73;
    set_regs(8'd0, 8'd0, 8'd250);
    hold_asks++;
    random_run(125);

    quiesce();
    idle_pct = 7;
    stall_pct = 7;
    set_regs(8'd5, 8'd15, 8'd10);
    random_run(125);

    quiesce();
    idle_pct = 0;
    stall_pct = 0;
    set_regs(8'($urandom_range(15)), 8'($urandom_range(15)), 8'd0);
    random_run(125);

    quiesce();
    $display("%0d input beats over five register settings and four idle mixes, %0d notes taken",
             beats_sent, notes_taken);
    $display("%0d result beats compared, %0d mismatches", checked, fail_cnt);
    if (fail_cnt == 0) begin
      $display("melody_note_tone_generator verification clean");
    end else begin
      $display("melody_note_tone_generator verification failed");
    end
    $finish;
  end

endmodule
